// ===== sv/tagged_int_stack_machine_assert.svh =====
// Assertion macros for the tagged integer stack machine.
`ifndef TAGGED_INT_STACK_MACHINE_ASSERT_SVH
`define TAGGED_INT_STACK_MACHINE_ASSERT_SVH

// Checks that a condition implies another at the same edge.
`define TISM_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Checks that a condition implies another at the next edge.
`define TISM_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/tism_pkg.sv =====
`default_nettype none
package tism_pkg;
    localparam logic [4:0] OP_PUSHACC   = 5'd0;
    localparam logic [4:0] OP_ACC       = 5'd1;
    localparam logic [4:0] OP_ADD       = 5'd2;
    localparam logic [4:0] OP_SUB       = 5'd3;
    localparam logic [4:0] OP_MUL       = 5'd4;
    localparam logic [4:0] OP_DIV       = 5'd5;
    localparam logic [4:0] OP_MOD       = 5'd6;
    localparam logic [4:0] OP_AND       = 5'd7;
    localparam logic [4:0] OP_OR        = 5'd8;
    localparam logic [4:0] OP_XOR       = 5'd9;
    localparam logic [4:0] OP_CONST     = 5'd19;
    localparam logic [4:0] OP_PUSHCONST = 5'd20;
    localparam logic [4:0] OP_STOP      = 5'd21;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_UNDER = 2'd3;

    localparam logic [63:0] TAG_ZERO = 64'd1;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [62:0] dividend;
        logic [62:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

// ===== sv/tism_div.sv =====
`default_nettype none
// Signed truncating divide of 63-bit operands, one quotient bit per cycle.
module tism_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tism_pkg::div_req_t req,
    output logic                   done,
    output logic [62:0]            result
);
    logic [62:0] rem_reg, rem_next;
    logic [62:0] quo_reg, quo_next;
    logic [62:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_q_reg, neg_r_reg, is_mod_reg;
    logic [63:0] trial;
    logic [62:0] qs, rs;

    assign done = done_reg;

    always_comb begin
        trial    = {rem_reg, quo_reg[62]} - {1'b0, den_reg};
        rem_next = trial[63] ? {rem_reg[61:0], quo_reg[62]} : trial[62:0];
        quo_next = {quo_reg[61:0], ~trial[63]};
        qs       = neg_q_reg ? 63'(-quo_reg) : quo_reg;
        rs       = neg_r_reg ? 63'(-rem_reg) : rem_reg;
        result   = is_mod_reg ? rs : qs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == '0);
            if (req.start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= 6'd62;
                is_mod_reg <= req.is_mod;
                neg_q_reg  <= req.dividend[62] ^ req.divisor[62];
                neg_r_reg  <= req.dividend[62];
                rem_reg    <= '0;
                quo_reg    <= req.dividend[62] ? 63'(-req.dividend) : req.dividend;
                den_reg    <= req.divisor[62] ? 63'(-req.divisor) : req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/tagged_int_stack_machine.sv =====
`default_nettype none
// Channel  Dir  tdata fields (low bit first)                  Other
// s_       in   req_type[4:0], operand[36:5] (40 bits)         -
// m_       out  accumulator[63:0], stack_depth[71:64],         -
//               halted[72], error_code[74:73] (80 bits)
// For each instruction, the stack top is first read from the
// synchronous stack memory, then the result is computed and written back.
// Multiply adds the cross products of its 32-bit halves in the multiply
// state; divide and modulo wait for the result of the bit-serial divider.
// One instruction is in flight at a time; the result sits in an output
// register until taken, and a new word is accepted in the same cycle it is
// taken. Reset clears the accumulator to tagged zero and the depth to zero;
// the stack memory is not cleared.
module tagged_int_stack_machine #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // req_type, operand
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // accumulator, stack_depth, halted, error_code
);
    `include "tagged_int_stack_machine_assert.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    state_t state_reg;
    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rd_data_reg;
    logic [63:0] accu_reg;
    logic [DW-1:0] depth_reg;
    logic [4:0]  op_reg;
    logic signed [31:0] imm_reg;
    logic [63:0] prod_reg;
    logic        mul_step_reg;
    logic        out_valid_reg;
    logic [79:0] out_data_reg;

    logic        s_acc;
    logic [4:0]  in_op;
    logic signed [31:0] in_imm;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0] wr_data;
    logic        in_push, in_unary;
    logic [62:0] ua, ut;
    logic [63:0] sa, sb;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p, mul_sum;
    tism_pkg::div_req_t div_req;
    logic        div_done;
    logic [62:0] div_res;
    logic        fin;
    logic [63:0] new_acc;
    logic [DW-1:0] new_depth;
    logic [1:0]  new_err;
    logic        new_halt;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign in_op    = s_tdata[4:0];
    assign in_imm   = s_tdata[36:5];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Decode at accept: compute the read address of the accumulator source
    // or the stack top. A pushacc with offset zero reads the accumulator, and
    // any other pushacc offset counts from the top after the push, so it
    // lands one entry higher than the same offset of acc.
    always_comb begin
        in_push  = (in_op == tism_pkg::OP_PUSHACC);
        in_unary = in_push || (in_op == tism_pkg::OP_ACC);
        if (in_push) begin
            rd_addr = AW'(depth_reg - DW'(in_imm));
        end else if (in_unary) begin
            rd_addr = AW'(depth_reg - DW'(1) - DW'(in_imm));
        end else begin
            rd_addr = AW'(depth_reg - DW'(1));
        end
        rd_en = s_acc;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign ua = accu_reg[63:1];
    assign ut = rd_data_reg[63:1];

    // The low 64 bits of the product are built from three 32 by 32 bit
    // products on one multiplier: the low halves in the execute cycle, then
    // each cross product added into the upper half.
    always_comb begin
        sa = {ua[62], ua};
        sb = {ut[62], ut};
        if (state_reg == ST_EXEC) begin
            mul_x = sa[31:0];
            mul_y = sb[31:0];
        end else if (!mul_step_reg) begin
            mul_x = sa[63:32];
            mul_y = sb[31:0];
        end else begin
            mul_x = sa[31:0];
            mul_y = sb[63:32];
        end
        mul_p   = 64'(mul_x) * 64'(mul_y);
        mul_sum = prod_reg + {mul_p[31:0], 32'd0};
    end

    always_comb begin
        div_req.start    = (state_reg == ST_EXEC) && depth_reg != '0 && ut != '0 &&
                           (op_reg == tism_pkg::OP_DIV || op_reg == tism_pkg::OP_MOD);
        div_req.is_mod   = (op_reg == tism_pkg::OP_MOD);
        div_req.dividend = ua;
        div_req.divisor  = ut;
    end

    tism_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .result  (div_res)
    );

    // Execute, multiply and divide states: form the new accumulator, depth, error code, halt flag and stack write.
    always_comb begin
        new_acc   = accu_reg;
        new_depth = depth_reg;
        new_err   = tism_pkg::ERR_OK;
        new_halt  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = AW'(depth_reg);
        wr_data   = accu_reg;
        fin       = 1'b0;
        unique case (state_reg)
            ST_EXEC: begin
                fin = 1'b1;
                case (op_reg)
                    tism_pkg::OP_PUSHACC: begin
                        if ((DW+1)'(depth_reg) >= (DW+1)'(STACK_DEPTH)) begin
                            new_err = tism_pkg::ERR_OVER;
                        end else if (imm_reg[31] ||
                                     {1'b0, imm_reg} >= 33'(depth_reg) + 33'd1) begin
                            new_err = tism_pkg::ERR_UNDER;
                        end else begin
                            wr_en     = 1'b1;
                            new_depth = depth_reg + DW'(1);
                            new_acc   = (imm_reg == 32'sd0) ? accu_reg : rd_data_reg;
                        end
                    end
                    tism_pkg::OP_ACC: begin
                        if (imm_reg[31] || {1'b0, imm_reg} >= 33'(depth_reg)) begin
                            new_err = tism_pkg::ERR_UNDER;
                        end else begin
                            new_acc = rd_data_reg;
                        end
                    end
                    tism_pkg::OP_CONST: begin
                        new_acc = {63'(signed'(imm_reg)), 1'b1};
                    end
                    tism_pkg::OP_PUSHCONST: begin
                        if ((DW+1)'(depth_reg) >= (DW+1)'(STACK_DEPTH)) begin
                            new_err = tism_pkg::ERR_OVER;
                        end else begin
                            wr_en     = 1'b1;
                            new_depth = depth_reg + DW'(1);
                            new_acc   = {63'(signed'(imm_reg)), 1'b1};
                        end
                    end
                    tism_pkg::OP_STOP: begin
                        new_halt = 1'b1;
                    end
                    default: begin
                        if (op_reg >= tism_pkg::OP_ADD && op_reg <= tism_pkg::OP_XOR) begin
                            if (depth_reg == '0) begin
                                new_err = tism_pkg::ERR_UNDER;
                            end else begin
                                new_depth = depth_reg - DW'(1);
                                case (op_reg)
                                    tism_pkg::OP_ADD: new_acc = accu_reg + rd_data_reg - 64'd1;
                                    tism_pkg::OP_SUB: new_acc = accu_reg - rd_data_reg + 64'd1;
                                    tism_pkg::OP_AND: new_acc = accu_reg & rd_data_reg;
                                    tism_pkg::OP_OR:  new_acc = accu_reg | rd_data_reg;
                                    tism_pkg::OP_XOR: new_acc = (accu_reg ^ rd_data_reg) | 64'd1;
                                    tism_pkg::OP_MUL: fin = 1'b0;
                                    default: begin
                                        if (ut == '0) begin
                                            new_err   = tism_pkg::ERR_DIV0;
                                            new_depth = depth_reg;
                                        end else begin
                                            fin = 1'b0;
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
            ST_MUL: begin
                fin       = mul_step_reg;
                new_acc   = {mul_sum[62:0], 1'b1};
                new_depth = depth_reg - DW'(1);
            end
            ST_DIV: begin
                fin       = div_done;
                new_acc   = {div_res, 1'b1};
                new_depth = depth_reg - DW'(1);
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            prod_reg     <= mul_p;
            mul_step_reg <= 1'b0;
        end else if (state_reg == ST_MUL) begin
            prod_reg     <= mul_sum;
            mul_step_reg <= 1'b1;
        end
        if (s_acc) begin
            op_reg  <= in_op;
            imm_reg <= in_imm;
        end
        if (fin) begin
            out_data_reg <= {5'd0, new_err, new_halt, 8'(new_depth), new_acc};
        end
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            accu_reg      <= tism_pkg::TAG_ZERO;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= fin || (out_valid_reg && !m_tready);
            if (fin) begin
                state_reg <= ST_IDLE;
                if (new_halt) begin
                    accu_reg  <= tism_pkg::TAG_ZERO;
                    depth_reg <= '0;
                end else begin
                    accu_reg  <= new_acc;
                    depth_reg <= new_depth;
                end
            end else begin
                unique case (state_reg)
                    ST_IDLE: if (s_acc) state_reg <= ST_EXEC;
                    ST_EXEC: state_reg <= (op_reg == tism_pkg::OP_MUL) ? ST_MUL : ST_DIV;
                    ST_MUL:  state_reg <= ST_MUL;
                    ST_DIV:  state_reg <= ST_DIV;
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    `TISM_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_acc, state_reg == ST_EXEC,
                      "accepted word did not start execution")
    `TISM_ASSERT_IMPL(a_depth_bound, aclk, aresetn, 1'b1,
                      (DW+1)'(depth_reg) <= (DW+1)'(STACK_DEPTH),
                      "stack depth beyond capacity")
    `TISM_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready,
                      "input ready while busy")
endmodule
`default_nettype wire
